### hdl/kf_pkg.sv
package kf_pkg;

  localparam int KF_W         = 64;
  localparam int KF_FRAC_BITS = 40;
  localparam int KF_NSLOT     = 32;
  localparam int KF_PC_W      = 7;

  typedef struct packed {
    logic signed [63:0] measurement;
    logic               restart;
  } kf_in_t;

  typedef struct packed {
    logic signed [63:0] est_pos;
    logic signed [63:0] est_vel;
    logic signed [63:0] cov_00;
    logic signed [63:0] cov_01;
    logic signed [63:0] cov_10;
    logic signed [63:0] cov_11;
    logic               gain_invalid;
    logic               saturated;
  } kf_out_t;

  typedef enum logic [2:0] {
    CFG_TRANS_00 = 3'd0,
    CFG_TRANS_01 = 3'd1,
    CFG_TRANS_10 = 3'd2,
    CFG_TRANS_11 = 3'd3,
    CFG_MEAS_H0  = 3'd4,
    CFG_MEAS_H1  = 3'd5,
    CFG_Q_NOISE  = 3'd6,
    CFG_R_NOISE  = 3'd7
  } kf_cfg_idx_t;

  typedef enum logic [4:0] {
    SL_F00, SL_F01, SL_F10, SL_F11, SL_H0, SL_H1, SL_QN, SL_RN,
    SL_X0, SL_X1, SL_C0, SL_C1, SL_C2, SL_C3, SL_Z, SL_ZERO,
    SL_T1, SL_T2, SL_XA, SL_A0, SL_A1, SL_A2, SL_A3, SL_PH0,
    SL_PH1, SL_S, SL_Y, SL_K0, SL_K1, SL_HP0, SL_HP1, SL_TMP
  } kf_slot_t;

  typedef enum logic [2:0] {
    OP_MUL, OP_DIV, OP_ADD, OP_SUB, OP_BLE, OP_END
  } kf_op_t;

  typedef struct packed {
    kf_op_t   op;
    kf_slot_t dst;
    kf_slot_t sa;
    kf_slot_t sb;
  } kf_uop_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH_A, ST_FETCH_B, ST_EXEC, ST_WAIT, ST_DONE
  } kf_st_t;

  typedef enum logic [2:0] {
    MD_IDLE, MD_MUL, MD_NEG, MD_RND, MD_DIV, MD_DFIN, MD_DONE
  } kf_md_st_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } kf_md_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } kf_md_rsp_t;

  function automatic kf_uop_t kf_ucode(input logic [KF_PC_W-1:0] pc);
    kf_uop_t u;
    u = '{OP_END, SL_ZERO, SL_ZERO, SL_ZERO};
    case (pc)
      7'd0:  u = '{OP_MUL, SL_T1,  SL_F00, SL_X0};
      7'd1:  u = '{OP_MUL, SL_T2,  SL_F01, SL_X1};
      7'd2:  u = '{OP_ADD, SL_XA,  SL_T1,  SL_T2};
      7'd3:  u = '{OP_MUL, SL_T1,  SL_F10, SL_X0};
      7'd4:  u = '{OP_MUL, SL_T2,  SL_F11, SL_X1};
      7'd5:  u = '{OP_ADD, SL_X1,  SL_T1,  SL_T2};
      7'd6:  u = '{OP_ADD, SL_X0,  SL_XA,  SL_ZERO};
      7'd7:  u = '{OP_MUL, SL_T1,  SL_F00, SL_C0};
      7'd8:  u = '{OP_MUL, SL_T2,  SL_F01, SL_C2};
      7'd9:  u = '{OP_ADD, SL_A0,  SL_T1,  SL_T2};
      7'd10: u = '{OP_MUL, SL_T1,  SL_F00, SL_C1};
      7'd11: u = '{OP_MUL, SL_T2,  SL_F01, SL_C3};
      7'd12: u = '{OP_ADD, SL_A1,  SL_T1,  SL_T2};
      7'd13: u = '{OP_MUL, SL_T1,  SL_F10, SL_C0};
      7'd14: u = '{OP_MUL, SL_T2,  SL_F11, SL_C2};
      7'd15: u = '{OP_ADD, SL_A2,  SL_T1,  SL_T2};
      7'd16: u = '{OP_MUL, SL_T1,  SL_F10, SL_C1};
      7'd17: u = '{OP_MUL, SL_T2,  SL_F11, SL_C3};
      7'd18: u = '{OP_ADD, SL_A3,  SL_T1,  SL_T2};
      7'd19: u = '{OP_MUL, SL_T1,  SL_A0,  SL_F00};
      7'd20: u = '{OP_MUL, SL_T2,  SL_A1,  SL_F01};
      7'd21: u = '{OP_ADD, SL_C0,  SL_T1,  SL_T2};
      7'd22: u = '{OP_ADD, SL_C0,  SL_C0,  SL_QN};
      7'd23: u = '{OP_MUL, SL_T1,  SL_A0,  SL_F10};
      7'd24: u = '{OP_MUL, SL_T2,  SL_A1,  SL_F11};
      7'd25: u = '{OP_ADD, SL_C1,  SL_T1,  SL_T2};
      7'd26: u = '{OP_MUL, SL_T1,  SL_A2,  SL_F00};
      7'd27: u = '{OP_MUL, SL_T2,  SL_A3,  SL_F01};
      7'd28: u = '{OP_ADD, SL_C2,  SL_T1,  SL_T2};
      7'd29: u = '{OP_MUL, SL_T1,  SL_A2,  SL_F10};
      7'd30: u = '{OP_MUL, SL_T2,  SL_A3,  SL_F11};
      7'd31: u = '{OP_ADD, SL_C3,  SL_T1,  SL_T2};
      7'd32: u = '{OP_ADD, SL_C3,  SL_C3,  SL_QN};
      7'd33: u = '{OP_MUL, SL_T1,  SL_C0,  SL_H0};
      7'd34: u = '{OP_MUL, SL_T2,  SL_C1,  SL_H1};
      7'd35: u = '{OP_ADD, SL_PH0, SL_T1,  SL_T2};
      7'd36: u = '{OP_MUL, SL_T1,  SL_C2,  SL_H0};
      7'd37: u = '{OP_MUL, SL_T2,  SL_C3,  SL_H1};
      7'd38: u = '{OP_ADD, SL_PH1, SL_T1,  SL_T2};
      7'd39: u = '{OP_MUL, SL_T1,  SL_H0,  SL_PH0};
      7'd40: u = '{OP_MUL, SL_T2,  SL_H1,  SL_PH1};
      7'd41: u = '{OP_ADD, SL_S,   SL_T1,  SL_T2};
      7'd42: u = '{OP_ADD, SL_S,   SL_S,   SL_RN};
      7'd43: u = '{OP_BLE, SL_ZERO, SL_S,  SL_ZERO};
      7'd44: u = '{OP_MUL, SL_T1,  SL_H0,  SL_X0};
      7'd45: u = '{OP_MUL, SL_T2,  SL_H1,  SL_X1};
      7'd46: u = '{OP_ADD, SL_TMP, SL_T1,  SL_T2};
      7'd47: u = '{OP_SUB, SL_Y,   SL_Z,   SL_TMP};
      7'd48: u = '{OP_DIV, SL_K0,  SL_PH0, SL_S};
      7'd49: u = '{OP_DIV, SL_K1,  SL_PH1, SL_S};
      7'd50: u = '{OP_MUL, SL_T1,  SL_K0,  SL_Y};
      7'd51: u = '{OP_ADD, SL_X0,  SL_X0,  SL_T1};
      7'd52: u = '{OP_MUL, SL_T1,  SL_K1,  SL_Y};
      7'd53: u = '{OP_ADD, SL_X1,  SL_X1,  SL_T1};
      7'd54: u = '{OP_MUL, SL_T1,  SL_H0,  SL_C0};
      7'd55: u = '{OP_MUL, SL_T2,  SL_H1,  SL_C2};
      7'd56: u = '{OP_ADD, SL_HP0, SL_T1,  SL_T2};
      7'd57: u = '{OP_MUL, SL_T1,  SL_H0,  SL_C1};
      7'd58: u = '{OP_MUL, SL_T2,  SL_H1,  SL_C3};
      7'd59: u = '{OP_ADD, SL_HP1, SL_T1,  SL_T2};
      7'd60: u = '{OP_MUL, SL_T1,  SL_K0,  SL_HP0};
      7'd61: u = '{OP_SUB, SL_C0,  SL_C0,  SL_T1};
      7'd62: u = '{OP_MUL, SL_T1,  SL_K0,  SL_HP1};
      7'd63: u = '{OP_SUB, SL_C1,  SL_C1,  SL_T1};
      7'd64: u = '{OP_MUL, SL_T1,  SL_K1,  SL_HP0};
      7'd65: u = '{OP_SUB, SL_C2,  SL_C2,  SL_T1};
      7'd66: u = '{OP_MUL, SL_T1,  SL_K1,  SL_HP1};
      7'd67: u = '{OP_SUB, SL_C3,  SL_C3,  SL_T1};
      default: u = '{OP_END, SL_ZERO, SL_ZERO, SL_ZERO};
    endcase
    return u;
  endfunction

endpackage

### hdl/kf_mdu.sv
module kf_mdu #(
  parameter int FRAC_BITS = kf_pkg::KF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  kf_pkg::kf_md_req_t req,
  input  logic [63:0]        opa,
  input  logic [63:0]        opb,
  output kf_pkg::kf_md_rsp_t rsp,
  output logic [63:0]        res
);
  import kf_pkg::*;

  localparam logic [127:0] RND   = 128'(1) << (FRAC_BITS - 1);
  localparam logic [63:0]  S_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0]  S_MIN = {1'b1, {63{1'b0}}};

  kf_md_st_t    st_r, st_nxt;
  logic [63:0]  ua_r, ua_nxt, ub_r, ub_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [63:0]  rem_r, rem_nxt, lo_r, lo_nxt, q_r, q_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic         neg_r, neg_nxt, sat_r, sat_nxt;
  logic [63:0]  res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= MD_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    ua_r  <= ua_nxt;
    ub_r  <= ub_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    sat_r <= sat_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    logic [63:0]  ma, hi, ah, bh, pp;
    logic [1:0]   sh;
    logic [127:0] t, r;
    logic [64:0]  r65;
    st_nxt  = st_r;
    ua_nxt  = ua_r;
    ub_nxt  = ub_r;
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    lo_nxt  = lo_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    sat_nxt = sat_r;
    res_nxt = res_r;
    ma  = opa[63] ? 64'(0) - opa : opa;
    hi  = ma >> (64 - FRAC_BITS);
    ah  = {32'b0, (cnt_r[0] ? ua_r[63:32] : ua_r[31:0])};
    bh  = {32'b0, (cnt_r[1] ? ub_r[63:32] : ub_r[31:0])};
    pp  = ah * bh;
    sh  = {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
    t   = acc_r + RND;
    r   = $signed(t) >>> FRAC_BITS;
    r65 = {rem_r, lo_r[63]};
    case (st_r)
      MD_IDLE: begin
        if (req.start) begin
          ua_nxt  = ma;
          cnt_nxt = '0;
          sat_nxt = 1'b0;
          if (req.is_div) begin
            neg_nxt = opa[63];
            ub_nxt  = opb;
            rem_nxt = hi;
            lo_nxt  = ma << FRAC_BITS;
            q_nxt   = '0;
            if (hi >= opb) begin
              sat_nxt = 1'b1;
              res_nxt = opa[63] ? S_MIN : S_MAX;
              st_nxt  = MD_DONE;
            end else begin
              st_nxt = MD_DIV;
            end
          end else begin
            neg_nxt = opa[63] ^ opb[63];
            ub_nxt  = opb[63] ? 64'(0) - opb : opb;
            acc_nxt = '0;
            st_nxt  = MD_MUL;
          end
        end
      end
      MD_MUL: begin
        case (sh)
          2'd0:    acc_nxt = acc_r + {64'b0, pp};
          2'd1:    acc_nxt = acc_r + {32'b0, pp, 32'b0};
          default: acc_nxt = acc_r + {pp, 64'b0};
        endcase
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r[1:0] == 2'd3) begin
          st_nxt = MD_NEG;
        end
      end
      MD_NEG: begin
        if (neg_r) begin
          acc_nxt = 128'(0) - acc_r;
        end
        st_nxt = MD_RND;
      end
      MD_RND: begin
        if (r[127:63] == {65{r[63]}}) begin
          res_nxt = r[63:0];
        end else begin
          sat_nxt = 1'b1;
          res_nxt = t[127] ? S_MIN : S_MAX;
        end
        st_nxt = MD_DONE;
      end
      MD_DIV: begin
        if (r65 >= {1'b0, ub_r}) begin
          rem_nxt = 64'(r65 - {1'b0, ub_r});
          q_nxt   = {q_r[62:0], 1'b1};
        end else begin
          rem_nxt = r65[63:0];
          q_nxt   = {q_r[62:0], 1'b0};
        end
        lo_nxt  = {lo_r[62:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          st_nxt = MD_DFIN;
        end
      end
      MD_DFIN: begin
        if (neg_r) begin
          if (q_r > S_MIN) begin
            sat_nxt = 1'b1;
            res_nxt = S_MIN;
          end else begin
            res_nxt = 64'(0) - q_r;
          end
        end else if (q_r > S_MAX) begin
          sat_nxt = 1'b1;
          res_nxt = S_MAX;
        end else begin
          res_nxt = q_r;
        end
        st_nxt = MD_DONE;
      end
      MD_DONE: begin
        st_nxt = MD_IDLE;
      end
      default: begin
        st_nxt = MD_IDLE;
      end
    endcase
  end

  assign rsp.done = (st_r == MD_DONE);
  assign rsp.sat  = sat_r;
  assign res      = res_r;

endmodule

### hdl/kalman_filter_two_state.sv
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  kf_in_t  (measurement, restart)
// out_     output     out_valid/out_stall kf_out_t (state, covariance, flags)
// cfg_     input      cfg_we             cfg_index, cfg_data
// The update is skipped, and gain_invalid set, when S is not positive.
// A 68-step microprogram runs on one register file and one shared
// multiply/divide unit.
// Reset is synchronous and loads F = I, H = 0, q = r = 1, x = 0, P = I.
// A finished result holds on out_ while a new request is taken.
module kalman_filter_two_state #(
  parameter int FRAC_BITS = kf_pkg::KF_FRAC_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  kf_pkg::kf_in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output kf_pkg::kf_out_t out_data,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [63:0]     cfg_data
);
  import kf_pkg::*;

  localparam logic [63:0] ONE   = 64'(1) << FRAC_BITS;
  localparam logic [63:0] S_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] S_MIN = {1'b1, {63{1'b0}}};

  logic [63:0]        rf_r [KF_NSLOT];
  kf_st_t             st_r, st_nxt;
  logic [KF_PC_W-1:0] pc_r, pc_nxt;
  logic [63:0]        opa_r, opa_nxt, opb_r, opb_nxt;
  logic               inv_r, inv_nxt, sat_r, sat_nxt;
  logic               ovld_r, ovld_nxt;
  kf_out_t            out_r, out_nxt;
  kf_uop_t            uc;
  logic               wr_en;
  kf_slot_t           wr_slot;
  logic [63:0]        wr_data;
  logic               in_acc;
  kf_md_req_t         md_req;
  kf_md_rsp_t         md_rsp;
  logic [63:0]        md_res;

  kf_mdu #(.FRAC_BITS(FRAC_BITS)) u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .opa   (opa_r),
    .opb   (opb_r),
    .rsp   (md_rsp),
    .res   (md_res)
  );

  assign uc       = kf_ucode(pc_r);
  assign in_stall = (st_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KF_NSLOT; i++) begin
        rf_r[5'(i)] <= (kf_slot_t'(i) inside {SL_F00, SL_F11, SL_QN, SL_RN, SL_C0, SL_C3}) ?
                       ONE : '0;
      end
      st_r   <= ST_IDLE;
      ovld_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ovld_r <= ovld_nxt;
      if (cfg_we) begin
        case (kf_cfg_idx_t'(cfg_index))
          CFG_TRANS_00: rf_r[SL_F00] <= cfg_data;
          CFG_TRANS_01: rf_r[SL_F01] <= cfg_data;
          CFG_TRANS_10: rf_r[SL_F10] <= cfg_data;
          CFG_TRANS_11: rf_r[SL_F11] <= cfg_data;
          CFG_MEAS_H0:  rf_r[SL_H0]  <= cfg_data;
          CFG_MEAS_H1:  rf_r[SL_H1]  <= cfg_data;
          CFG_Q_NOISE:  rf_r[SL_QN]  <= {1'b0, cfg_data[62:0]};
          CFG_R_NOISE:  rf_r[SL_RN]  <= {1'b0, cfg_data[62:0]};
          default: ;
        endcase
      end
      if (in_acc) begin
        rf_r[SL_Z] <= in_data.measurement;
        if (in_data.restart) begin
          rf_r[SL_X0] <= in_data.measurement;
          rf_r[SL_X1] <= '0;
          rf_r[SL_C0] <= ONE;
          rf_r[SL_C1] <= '0;
          rf_r[SL_C2] <= '0;
          rf_r[SL_C3] <= ONE;
        end
      end
      if (wr_en) begin
        rf_r[wr_slot] <= wr_data;
      end
    end
    pc_r  <= pc_nxt;
    opa_r <= opa_nxt;
    opb_r <= opb_nxt;
    inv_r <= inv_nxt;
    sat_r <= sat_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    logic [64:0] s65;
    st_nxt   = st_r;
    pc_nxt   = pc_r;
    opa_nxt  = opa_r;
    opb_nxt  = opb_r;
    inv_nxt  = inv_r;
    sat_nxt  = sat_r;
    out_nxt  = out_r;
    ovld_nxt = ovld_r && out_stall;
    wr_en    = 1'b0;
    wr_slot  = uc.dst;
    wr_data  = md_res;
    md_req   = '0;
    if (uc.op == OP_SUB) begin
      s65 = {opa_r[63], opa_r} - {opb_r[63], opb_r};
    end else begin
      s65 = {opa_r[63], opa_r} + {opb_r[63], opb_r};
    end
    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          pc_nxt  = '0;
          inv_nxt = 1'b0;
          sat_nxt = 1'b0;
          st_nxt  = ST_FETCH_A;
        end
      end
      ST_FETCH_A: begin
        opa_nxt = rf_r[uc.sa];
        st_nxt  = (uc.op == OP_END) ? ST_DONE : ST_FETCH_B;
      end
      ST_FETCH_B: begin
        opb_nxt = rf_r[uc.sb];
        if (uc.op == OP_BLE) begin
          if ($signed(opa_r) <= 0) begin
            inv_nxt = 1'b1;
            st_nxt  = ST_DONE;
          end else begin
            pc_nxt = pc_r + 1'b1;
            st_nxt = ST_FETCH_A;
          end
        end else begin
          st_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (uc.op == OP_MUL || uc.op == OP_DIV) begin
          md_req.start  = 1'b1;
          md_req.is_div = (uc.op == OP_DIV);
          st_nxt        = ST_WAIT;
        end else begin
          wr_en = 1'b1;
          if (s65[64] != s65[63]) begin
            wr_data = s65[64] ? S_MIN : S_MAX;
            sat_nxt = 1'b1;
          end else begin
            wr_data = s65[63:0];
          end
          pc_nxt = pc_r + 1'b1;
          st_nxt = ST_FETCH_A;
        end
      end
      ST_WAIT: begin
        if (md_rsp.done) begin
          wr_en   = 1'b1;
          sat_nxt = sat_r | md_rsp.sat;
          pc_nxt  = pc_r + 1'b1;
          st_nxt  = ST_FETCH_A;
        end
      end
      ST_DONE: begin
        if (!ovld_r || !out_stall) begin
          out_nxt.est_pos      = rf_r[SL_X0];
          out_nxt.est_vel      = rf_r[SL_X1];
          out_nxt.cov_00       = rf_r[SL_C0];
          out_nxt.cov_01       = rf_r[SL_C1];
          out_nxt.cov_10       = rf_r[SL_C2];
          out_nxt.cov_11       = rf_r[SL_C3];
          out_nxt.gain_invalid = inv_r;
          out_nxt.saturated    = sat_r;
          ovld_nxt             = 1'b1;
          st_nxt               = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = ovld_r;
  assign out_data  = out_r;

endmodule

### hdl/kf_chk.sv
module kf_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input kf_pkg::kf_out_t out_data
);

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_no_result_on_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared right after request");

endmodule

bind kalman_filter_two_state kf_chk u_kf_chk (.*);
